>>> src/sfdc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the scheduled fan duty controller
// no dependencies; imported by sfdc_div and scheduled_fan_duty_controller
package sfdc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;
    localparam int TEMP_W     = 12;
    localparam int MIN_W      = 11;
    localparam int DUTY_W     = 7;
    localparam int NUM_W      = 19;
    localparam int QUOT_W     = 7;
    localparam int RULE_REGS  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RULE0  = 3'd2;

    localparam logic signed [TEMP_W-1:0] AUTO_TMIN = 12'sd240;
    localparam logic signed [TEMP_W-1:0] AUTO_TMAX = 12'sd400;
    localparam logic [DUTY_W-1:0]        DUTY_MAX  = 7'd100;

    typedef enum logic [1:0] {
        MODE_MANUAL,
        MODE_AUTO,
        MODE_SCHED,
        MODE_HOLD
    } t_mode;

    typedef struct packed {
        logic signed [TEMP_W-1:0] tmax;
        logic signed [TEMP_W-1:0] tmin;
        logic [MIN_W-1:0]         stop_min;
        logic [MIN_W-1:0]         open_min;
        logic                     active;
    } t_rule;

    // window wraps past midnight when start >= stop
    function automatic logic f_in_window(input logic [MIN_W-1:0] now,
                                         input logic [MIN_W-1:0] open_min,
                                         input logic [MIN_W-1:0] stop_min);
        logic hit;
        if (open_min < stop_min) begin
            hit = (now >= open_min) && (now < stop_min);
        end else begin
            hit = (now >= open_min) || (now < stop_min);
        end
        return hit;
    endfunction

endpackage

>>> src/sfdc_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle, 7-bit quotient
// depends on sfdc_pkg; quotient must be known to fit in QUOT_W bits
module sfdc_div
    import sfdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [TEMP_W-1:0]     i_den,
    output logic                  o_done,
    output logic [QUOT_W-1:0]     o_quot
);

    localparam int DIV_W = TEMP_W + QUOT_W - 1;

    logic                 r_busy;
    logic [2:0]           r_cnt;
    logic [NUM_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [QUOT_W-1:0]    r_quot;
    logic                 r_done;

    logic                 w_ge;
    logic [NUM_W-1:0]     n_rem;

    assign w_ge  = r_rem >= NUM_W'(r_div);
    assign n_rem = w_ge ? (r_rem - NUM_W'(r_div)) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'(QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_div  <= {i_den, (QUOT_W-1)'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_div  <= r_div >> 1;
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> src/scheduled_fan_duty_controller.sv
`timescale 1ns / 1ps
// Fan duty controller: takes one sensor word at a time and returns one duty word
// (0..100). Manual and hold modes go straight to the finish state. A ramp inside
// its band uses the 7-step shared restoring divider; scheduled mode checks the
// stored rules in order, up to min(NUM_RULES, 3) (at most 3 rules are stored). The
// input is not ready while a word is in work; the output register lets the next
// word enter while a finished duty waits to be taken.
// depends on sfdc_pkg and sfdc_div
module scheduled_fan_duty_controller
    import sfdc_pkg::*;
#(
    parameter int NUM_RULES = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [TEMP_W-1:0]     i_temperature,
    input  logic                         i_presence,
    input  logic                         i_time_valid,
    input  logic [MIN_W-1:0]             i_minute_of_day,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [DUTY_W-1:0]            o_duty_percent
);

    localparam int RULE_STORE = (NUM_RULES < RULE_REGS) ? NUM_RULES : RULE_REGS;
    localparam int IDX_W      = (RULE_STORE > 1) ? $clog2(RULE_STORE) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RAMP,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state                    r_state;
    t_mode                     r_mode;
    logic [7:0]                r_manual;
    t_rule                     r_rules [RULE_STORE];
    logic [DUTY_W-1:0]         r_last_duty;
    logic [DUTY_W-1:0]         r_result;
    logic [IDX_W-1:0]          r_idx;
    logic signed [TEMP_W-1:0]  r_temp;
    logic signed [TEMP_W-1:0]  r_tmin;
    logic signed [TEMP_W-1:0]  r_tmax;
    logic [MIN_W-1:0]          r_minute;
    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_out_duty;

    logic                      w_accept;
    logic                      w_out_free;
    t_rule                     w_rule;
    logic                      w_hit;
    logic                      w_t_low;
    logic                      w_t_high;
    logic signed [TEMP_W:0]    w_span;
    logic signed [TEMP_W:0]    w_diff;
    logic [NUM_W-1:0]          w_num;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [QUOT_W-1:0]         w_quot;
    logic [DUTY_W-1:0]         w_manual_sat;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_manual_sat = (r_manual > 8'(DUTY_MAX)) ? DUTY_MAX : r_manual[DUTY_W-1:0];

    assign w_rule = r_rules[r_idx];
    assign w_hit  = w_rule.active &&
                    f_in_window(r_minute, w_rule.open_min, w_rule.stop_min);

    assign w_t_low  = r_temp <= r_tmin;
    assign w_t_high = r_temp >= r_tmax;
    assign w_span   = (TEMP_W+1)'(r_tmax) - (TEMP_W+1)'(r_tmin);
    assign w_diff   = (TEMP_W+1)'(r_temp) - (TEMP_W+1)'(r_tmin);
    // (t - tmin) * 100, positive on the division path
    assign w_num    = NUM_W'(w_diff[TEMP_W-1:0]) * NUM_W'(100);
    assign w_div_start = (r_state == ST_RAMP) && !w_t_low && !w_t_high && (w_span > 13'sd1);

    sfdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_span[TEMP_W-1:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MANUAL;
            r_manual <= '0;
            for (int g = 0; g < RULE_STORE; g++) begin
                r_rules[g] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE) begin
                r_mode <= t_mode'(i_cfg_data[1:0]);
            end
            if (i_cfg_idx == REG_MANUAL) begin
                r_manual <= i_cfg_data[7:0];
            end
            for (int g = 0; g < RULE_STORE; g++) begin
                if (i_cfg_idx == REG_RULE0 + CFG_IDX_W'(g)) begin
                    r_rules[g] <= t_rule'(i_cfg_data);
                end
            end
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_temp   <= i_temperature;
            r_minute <= i_minute_of_day;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last_duty <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx <= '0;
                        case (r_mode)
                            MODE_MANUAL: begin
                                r_result <= w_manual_sat;
                                r_state  <= ST_FINISH;
                            end
                            MODE_AUTO: begin
                                r_tmin   <= AUTO_TMIN;
                                r_tmax   <= AUTO_TMAX;
                                r_result <= '0;
                                r_state  <= i_presence ? ST_RAMP : ST_FINISH;
                            end
                            MODE_SCHED: begin
                                r_result <= '0;
                                r_state  <= (i_presence && i_time_valid) ? ST_SCAN
                                                                         : ST_FINISH;
                            end
                            default: begin
                                r_result <= r_last_duty;
                                r_state  <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (w_hit) begin
                        r_tmin  <= w_rule.tmin;
                        r_tmax  <= w_rule.tmax;
                        r_state <= ST_RAMP;
                    end else if (r_idx == IDX_W'(RULE_STORE - 1)) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_RAMP: begin
                    if (w_t_low) begin
                        r_result <= '0;
                        r_state  <= ST_FINISH;
                    end else if (w_t_high || !w_div_start) begin
                        r_result <= DUTY_MAX;
                        r_state  <= ST_FINISH;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_result <= w_quot;
                        r_state  <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_duty  <= r_result;
                        r_last_duty <= r_result;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_duty_percent = r_out_duty;

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_duty_percent <= DUTY_MAX)
        else $error("duty word above 100");

    a_out_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_duty_percent == r_last_duty)
        else $error("shown duty differs from held duty");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second word accepted while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV)
        else $error("divider finished outside division state");

endmodule
